### hw/rtl/ultrasonic_echo_ranger_defines.svh
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_defines.svh
// Assertion macros shared by the checker files of the echo ranger
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_RANGER_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define UER_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define UER_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg
// Types, codes and fixed constants of the ultrasonic echo ranger
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package uer_pkg;

   localparam int TRIG_BITS       = 8;
   localparam int TIMEOUT_BITS    = 22;
   localparam int HEIGHT_BITS     = 16;
   localparam int DEN_BITS        = 22;
   localparam int STATUS_BITS     = 2;
   localparam int DIST_BITS       = 21;
   localparam int LEVEL_BITS      = 16;
   localparam int ADDR_BITS       = 5;
   localparam int DATA_BITS       = 32;

   localparam int US_PER_CM       = 58;
   localparam int DIST_SHIFT      = 3;
   localparam int DIST_DIVISOR    = US_PER_CM / 2;
   localparam int LEVEL_FRAC_BITS = 14;
   localparam int LEVEL_ONE       = 16384;
   localparam int LEVEL_SAT_CEIL  = 49152;
   localparam logic signed [LEVEL_BITS-1:0] LEVEL_MIN = 16'sh8000;

   localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_PING_TO = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_ECHO_TO = 2'd2;

   localparam logic [TRIG_BITS-1:0]    TRIG_LOW_RESET  = 8'd4;
   localparam logic [TRIG_BITS-1:0]    TRIG_HIGH_RESET = 8'd10;
   localparam logic [TIMEOUT_BITS-1:0] PING_TO_RESET   = 22'd20000;
   localparam logic [TIMEOUT_BITS-1:0] ECHO_TO_RESET   = 22'd2320000;
   localparam logic [HEIGHT_BITS-1:0]  TANK_H_RESET    = 16'd100;

   typedef enum logic [2:0] {
      REG_TRIG_LOW,
      REG_TRIG_HIGH,
      REG_PING_TO,
      REG_ECHO_TO,
      REG_TANK_H
   } reg_index_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LOW,
      PH_HIGH,
      PH_WAIT,
      PH_ECHO
   } phase_type;

   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_DIST,
      ENG_LEVEL,
      ENG_HOLD
   } eng_type;

   typedef struct packed {
      logic [TRIG_BITS-1:0]    trig_low;
      logic [TRIG_BITS-1:0]    trig_high;
      logic [TIMEOUT_BITS-1:0] ping_to;
      logic [TIMEOUT_BITS-1:0] echo_to;
      logic [HEIGHT_BITS-1:0]  tank_h;
   } cfg_type;

   typedef struct packed {
      logic                   trigger_drive;
      logic                   drive_enable;
      logic                   busy;
      logic                   done;
      logic [STATUS_BITS-1:0] status;
      logic                   finish;
   } seq_out_type;

endpackage

### hw/rtl/uer_seq.sv
// ----------------------------------------------------------------------------
// uer_seq
// Per-tick measurement sequencer: trigger pulse, echo wait and echo count
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uer_seq #(
   parameter int COUNT_BITS = 22
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic                    operation,
   input  logic                    echo_level,
   input  uer_pkg::cfg_type        cfg,
   output uer_pkg::seq_out_type    seq_out,
   output logic [COUNT_BITS-1:0]   width
);

   localparam int CMP_BITS = (COUNT_BITS > uer_pkg::TIMEOUT_BITS) ?
                             COUNT_BITS : uer_pkg::TIMEOUT_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   uer_pkg::phase_type               phase_ff, phase_in;
   logic [COUNT_BITS-1:0]            tick_ff, tick_in, tick_bump;
   logic [uer_pkg::STATUS_BITS-1:0]  status_ff, status_in;
   logic                             done_ff, done_in;
   logic                             finish;
   logic [CMP_BITS-1:0]              bump_ext;
   logic                             at_max, low_end, high_end;
   logic                             ping_exp, echo_exp, echo_exp_first;

   // counter step and limit checks
   always_comb begin
      tick_bump      = (tick_ff == COUNT_MAX) ? tick_ff : tick_ff + 1'b1;
      at_max         = (tick_bump == COUNT_MAX);
      bump_ext       = CMP_BITS'(tick_bump);
      low_end        = bump_ext >= CMP_BITS'(cfg.trig_low);
      high_end       = bump_ext >= CMP_BITS'(cfg.trig_high);
      ping_exp       = (bump_ext >= CMP_BITS'(cfg.ping_to)) || at_max;
      echo_exp       = (bump_ext >= CMP_BITS'(cfg.echo_to)) || at_max;
      echo_exp_first = CMP_BITS'(cfg.echo_to) <= CMP_BITS'(1);
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         unique case (phase_ff)
            uer_pkg::PH_IDLE: begin
               if (operation) begin
                  phase_in = (cfg.trig_low != '0) ? uer_pkg::PH_LOW : uer_pkg::PH_HIGH;
               end
            end
            uer_pkg::PH_LOW: begin
               if (low_end) begin
                  phase_in = uer_pkg::PH_HIGH;
               end
            end
            uer_pkg::PH_HIGH: begin
               if (high_end) begin
                  phase_in = uer_pkg::PH_WAIT;
               end
            end
            uer_pkg::PH_WAIT: begin
               if (echo_level) begin
                  phase_in = echo_exp_first ? uer_pkg::PH_IDLE : uer_pkg::PH_ECHO;
               end else if (ping_exp) begin
                  phase_in = uer_pkg::PH_IDLE;
               end
            end
            uer_pkg::PH_ECHO: begin
               if (!echo_level || echo_exp) begin
                  phase_in = uer_pkg::PH_IDLE;
               end
            end
            default: begin
               phase_in = uer_pkg::PH_IDLE;
            end
         endcase
      end
   end

   // counter, status and done
   always_comb begin
      tick_in   = tick_ff;
      status_in = status_ff;
      done_in   = done_ff;
      finish    = 1'b0;
      if (step) begin
         done_in = 1'b0;
         unique case (phase_ff)
            uer_pkg::PH_IDLE: begin
               if (operation) begin
                  tick_in = '0;
               end
            end
            uer_pkg::PH_LOW: begin
               tick_in = low_end ? '0 : tick_bump;
            end
            uer_pkg::PH_HIGH: begin
               tick_in = high_end ? '0 : tick_bump;
            end
            uer_pkg::PH_WAIT: begin
               if (echo_level) begin
                  tick_in = COUNT_BITS'(1);
                  if (echo_exp_first) begin
                     status_in = uer_pkg::ST_ECHO_TO;
                     done_in   = 1'b1;
                  end
               end else begin
                  tick_in = tick_bump;
                  if (ping_exp) begin
                     status_in = uer_pkg::ST_PING_TO;
                     done_in   = 1'b1;
                  end
               end
            end
            uer_pkg::PH_ECHO: begin
               if (echo_level) begin
                  tick_in = tick_bump;
                  if (echo_exp) begin
                     status_in = uer_pkg::ST_ECHO_TO;
                     done_in   = 1'b1;
                  end
               end else begin
                  status_in = uer_pkg::ST_OK;
                  done_in   = 1'b1;
                  finish    = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // outputs
   always_comb begin
      seq_out.trigger_drive = (phase_ff == uer_pkg::PH_HIGH);
      seq_out.drive_enable  = (phase_ff == uer_pkg::PH_HIGH) || (phase_ff == uer_pkg::PH_LOW);
      seq_out.busy          = (phase_ff != uer_pkg::PH_IDLE);
      seq_out.done          = done_ff;
      seq_out.status        = status_ff;
      seq_out.finish        = finish;
      width                 = tick_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= uer_pkg::PH_IDLE;
         tick_ff   <= '0;
         status_ff <= uer_pkg::ST_OK;
         done_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         tick_ff   <= tick_in;
         status_ff <= status_in;
         done_ff   <= done_in;
      end
   end

endmodule

### hw/rtl/uer_div.sv
// ----------------------------------------------------------------------------
// uer_div
// Bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uer_div #(
   parameter int DVD_BITS = 36
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [DVD_BITS-1:0]           dividend,
   input  logic [uer_pkg::DEN_BITS-1:0]  divisor,
   output logic [DVD_BITS-1:0]           quotient,
   output logic                          rem_nonzero,
   output logic                          done
);

   localparam int CNT_BITS = $clog2(DVD_BITS);
   localparam int DEN_BITS = uer_pkg::DEN_BITS;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [DVD_BITS-1:0]  acc_ff, acc_in;
   logic [DEN_BITS-1:0]  rem_ff, rem_in;
   logic [DEN_BITS-1:0]  dsr_ff, dsr_in;
   logic [DEN_BITS:0]    rem_sh, rem_diff;
   logic                 fits, last;

   always_comb begin
      rem_sh   = {rem_ff, acc_ff[DVD_BITS-1]};
      rem_diff = rem_sh - {1'b0, dsr_ff};
      fits     = rem_sh >= {1'b0, dsr_ff};
      last     = (count_ff == CNT_BITS'(DVD_BITS - 1));
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = busy_ff && last;
      count_in = count_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         acc_in   = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         busy_in  = !last;
         count_in = count_ff + 1'b1;
         acc_in   = {acc_ff[DVD_BITS-2:0], fits};
         rem_in   = fits ? rem_diff[DEN_BITS-1:0] : rem_sh[DEN_BITS-1:0];
      end
   end

   assign quotient    = acc_ff;
   assign rem_nonzero = (rem_ff != '0);
   assign done        = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

endmodule

### hw/rtl/ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Single-pin ultrasonic ranger stepped by microsecond ticks, with distance
// and tank fill level computed on a shared bit-serial divider
// ----------------------------------------------------------------------------
// channel  direction  handshake             payload
// req      in         req_valid/req_stall   operation, echo_level
// rsp      out        rsp_valid/rsp_stall   pin drive, busy, done, status, distance, level
// csr      in/out     psel/penable/pready   five registers at byte address 4*index
//
// a tick transaction waits in the engine hold state until the output register is free
// the transaction that ends a good echo runs two divisions on the shared divider,
// one quotient bit per cycle, distance first, then level
// one transaction in flight; the next is taken while a result waits in the output register
// ready once synchronous reset is released, no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ultrasonic_echo_ranger #(
   parameter int COUNT_BITS = 22
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_operation,
   input  logic                                   req_echo_level,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_trigger_drive,
   output logic                                   rsp_drive_enable,
   output logic                                   rsp_busy_res,
   output logic                                   rsp_done_res,
   output logic [uer_pkg::STATUS_BITS-1:0]        rsp_status,
   output logic [uer_pkg::DIST_BITS-1:0]          rsp_distance_x16,
   output logic signed [uer_pkg::LEVEL_BITS-1:0]  rsp_level_q14,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [uer_pkg::ADDR_BITS-1:0]          csr_paddr,
   input  logic [uer_pkg::DATA_BITS-1:0]          csr_pwdata,
   output logic [uer_pkg::DATA_BITS-1:0]          csr_prdata,
   output logic                                   csr_pready
);

   localparam int DVD_BITS   = COUNT_BITS + uer_pkg::LEVEL_FRAC_BITS;
   localparam int DEN_BITS   = uer_pkg::DEN_BITS;
   localparam int DIST_BITS  = uer_pkg::DIST_BITS;
   localparam int LEVEL_BITS = uer_pkg::LEVEL_BITS;

   uer_pkg::cfg_type              cfg_ff, cfg_in;
   uer_pkg::reg_index_type        csr_index;
   logic                          csr_wr;

   uer_pkg::eng_type              eng_ff, eng_in;
   uer_pkg::seq_out_type          seq_out;
   logic [COUNT_BITS-1:0]         seq_width;
   logic [COUNT_BITS-1:0]         width_ff, width_in;
   logic                          accept, out_free, out_load;
   logic                          div_start, div_done, div_rem_nz;
   logic                          dist_store, level_store, use_level;
   logic [DVD_BITS-1:0]           div_dividend, div_quotient;
   logic [DEN_BITS-1:0]           div_divisor, height_ext, den;

   logic [DIST_BITS-1:0]          last_distance_ff, last_distance_in;
   logic signed [LEVEL_BITS-1:0]  last_level_ff, last_level_in;
   logic [LEVEL_BITS:0]           level_raw;
   logic                          level_sat;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_trigger_drive_ff, rsp_drive_enable_ff;
   logic                               rsp_busy_res_ff, rsp_done_res_ff;
   logic [uer_pkg::STATUS_BITS-1:0]    rsp_status_ff;
   logic [DIST_BITS-1:0]               rsp_distance_x16_ff;
   logic signed [LEVEL_BITS-1:0]       rsp_level_q14_ff;

   // register port
   always_comb begin
      csr_pready = 1'b1;
      csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
      csr_index  = uer_pkg::reg_index_type'(csr_paddr[uer_pkg::ADDR_BITS-1:2]);
      cfg_in     = cfg_ff;
      csr_prdata = '0;
      unique case (csr_index)
         uer_pkg::REG_TRIG_LOW: begin
            csr_prdata = 32'(cfg_ff.trig_low);
            if (csr_wr) cfg_in.trig_low = csr_pwdata[uer_pkg::TRIG_BITS-1:0];
         end
         uer_pkg::REG_TRIG_HIGH: begin
            csr_prdata = 32'(cfg_ff.trig_high);
            if (csr_wr) cfg_in.trig_high = csr_pwdata[uer_pkg::TRIG_BITS-1:0];
         end
         uer_pkg::REG_PING_TO: begin
            csr_prdata = 32'(cfg_ff.ping_to);
            if (csr_wr) cfg_in.ping_to = csr_pwdata[uer_pkg::TIMEOUT_BITS-1:0];
         end
         uer_pkg::REG_ECHO_TO: begin
            csr_prdata = 32'(cfg_ff.echo_to);
            if (csr_wr) cfg_in.echo_to = csr_pwdata[uer_pkg::TIMEOUT_BITS-1:0];
         end
         uer_pkg::REG_TANK_H: begin
            csr_prdata = 32'(cfg_ff.tank_h);
            if (csr_wr) cfg_in.tank_h = csr_pwdata[uer_pkg::HEIGHT_BITS-1:0];
         end
         default: begin
         end
      endcase
   end

   assign accept = req_valid && !req_stall;

   uer_seq #(
      .COUNT_BITS (COUNT_BITS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .step       (accept),
      .operation  (req_operation),
      .echo_level (req_echo_level),
      .cfg        (cfg_ff),
      .seq_out    (seq_out),
      .width      (seq_width)
   );

   // zero height counts as one centimeter
   always_comb begin
      height_ext = (cfg_ff.tank_h == '0) ? DEN_BITS'(1) : DEN_BITS'(cfg_ff.tank_h);
      den        = height_ext * DEN_BITS'(uer_pkg::US_PER_CM);
   end

   always_comb begin
      div_dividend = use_level ? {width_ff, {uer_pkg::LEVEL_FRAC_BITS{1'b0}}} :
                                 DVD_BITS'({seq_width, {uer_pkg::DIST_SHIFT{1'b0}}});
      div_divisor  = use_level ? den : DEN_BITS'(uer_pkg::DIST_DIVISOR);
   end

   uer_div #(
      .DVD_BITS (DVD_BITS)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .dividend    (div_dividend),
      .divisor     (div_divisor),
      .quotient    (div_quotient),
      .rem_nonzero (div_rem_nz),
      .done        (div_done)
   );

   // level = 16384 - ceil(width * 16384 / den), floored at -2.0
   always_comb begin
      level_sat = (div_quotient >= DVD_BITS'(uer_pkg::LEVEL_SAT_CEIL)) ||
                  ((div_quotient == DVD_BITS'(uer_pkg::LEVEL_SAT_CEIL - 1)) && div_rem_nz);
      level_raw = (LEVEL_BITS + 1)'(uer_pkg::LEVEL_ONE) - {1'b0, div_quotient[LEVEL_BITS-1:0]}
                  - (LEVEL_BITS + 1)'(div_rem_nz);
   end

   // engine next state
   always_comb begin
      eng_in = eng_ff;
      unique case (eng_ff)
         uer_pkg::ENG_IDLE: begin
            if (accept) begin
               eng_in = seq_out.finish ? uer_pkg::ENG_DIST : uer_pkg::ENG_HOLD;
            end
         end
         uer_pkg::ENG_DIST: begin
            if (div_done) eng_in = uer_pkg::ENG_LEVEL;
         end
         uer_pkg::ENG_LEVEL: begin
            if (div_done) eng_in = uer_pkg::ENG_HOLD;
         end
         uer_pkg::ENG_HOLD: begin
            if (out_free) eng_in = uer_pkg::ENG_IDLE;
         end
         default: begin
            eng_in = uer_pkg::ENG_IDLE;
         end
      endcase
   end

   // engine outputs
   always_comb begin
      out_free    = !rsp_valid_ff || !rsp_stall;
      req_stall   = (eng_ff != uer_pkg::ENG_IDLE);
      use_level   = (eng_ff != uer_pkg::ENG_IDLE);
      dist_store  = (eng_ff == uer_pkg::ENG_DIST) && div_done;
      level_store = (eng_ff == uer_pkg::ENG_LEVEL) && div_done;
      div_start   = ((eng_ff == uer_pkg::ENG_IDLE) && accept && seq_out.finish) || dist_store;
      out_load    = (eng_ff == uer_pkg::ENG_HOLD) && out_free;
   end

   always_comb begin
      width_in         = div_start && !use_level ? seq_width : width_ff;
      last_distance_in = dist_store ? div_quotient[DIST_BITS-1:0] : last_distance_ff;
      last_level_in    = last_level_ff;
      if (level_store) begin
         last_level_in = level_sat ? uer_pkg::LEVEL_MIN : level_raw[LEVEL_BITS-1:0];
      end
      rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trig_low  <= uer_pkg::TRIG_LOW_RESET;
         cfg_ff.trig_high <= uer_pkg::TRIG_HIGH_RESET;
         cfg_ff.ping_to   <= uer_pkg::PING_TO_RESET;
         cfg_ff.echo_to   <= uer_pkg::ECHO_TO_RESET;
         cfg_ff.tank_h    <= uer_pkg::TANK_H_RESET;
         eng_ff           <= uer_pkg::ENG_IDLE;
         last_distance_ff <= '0;
         last_level_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         cfg_ff           <= cfg_in;
         eng_ff           <= eng_in;
         last_distance_ff <= last_distance_in;
         last_level_ff    <= last_level_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      width_ff <= width_in;
      if (out_load) begin
         rsp_trigger_drive_ff <= seq_out.trigger_drive;
         rsp_drive_enable_ff  <= seq_out.drive_enable;
         rsp_busy_res_ff      <= seq_out.busy;
         rsp_done_res_ff      <= seq_out.done;
         rsp_status_ff        <= seq_out.status;
         rsp_distance_x16_ff  <= last_distance_ff;
         rsp_level_q14_ff     <= last_level_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_trigger_drive = rsp_trigger_drive_ff;
   assign rsp_drive_enable  = rsp_drive_enable_ff;
   assign rsp_busy_res      = rsp_busy_res_ff;
   assign rsp_done_res      = rsp_done_res_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_distance_x16  = rsp_distance_x16_ff;
   assign rsp_level_q14     = rsp_level_q14_ff;

endmodule

### hw/rtl/uer_checker.sv
// ----------------------------------------------------------------------------
// uer_checker
// Port-level checks of the echo ranger, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ultrasonic_echo_ranger_defines.svh"

module uer_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic                                  rsp_trigger_drive,
   input logic                                  rsp_drive_enable,
   input logic                                  rsp_busy_res,
   input logic                                  rsp_done_res,
   input logic [uer_pkg::STATUS_BITS-1:0]       rsp_status,
   input logic [uer_pkg::DIST_BITS-1:0]         rsp_distance_x16,
   input logic signed [uer_pkg::LEVEL_BITS-1:0] rsp_level_q14
);

   `UER_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_status) && $stable(rsp_distance_x16) && $stable(rsp_level_q14),
      "stalled result changed")

   `UER_ASSERT_NEXT(a_one_in_flight, req_valid && !req_stall, req_stall,
      "second transaction taken before the first result was queued")

   `UER_ASSERT_IMP(a_drive_needs_enable, rsp_valid && rsp_trigger_drive, rsp_drive_enable,
      "pin driven high while released")

   `UER_ASSERT_IMP(a_done_not_busy, rsp_valid && (rsp_done_res || rsp_drive_enable),
      rsp_busy_res != rsp_done_res,
      "done and busy disagree")

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (.*);

### dv/ultrasonic_echo_ranger_checker.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_checker
// Watches the request, result and register ports of the echo ranger. Every
// accepted request is run through a cycle-free model of the ranging sequence
// and divider math, and every accepted result is compared against the oldest
// predicted reading. Register writes are mirrored into the model's settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_checker #(
   parameter int COUNT_BITS = 22
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_stall,
   input  logic                                   req_operation,
   input  logic                                   req_echo_level,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   input  logic                                   rsp_trigger_drive,
   input  logic                                   rsp_drive_enable,
   input  logic                                   rsp_busy_res,
   input  logic                                   rsp_done_res,
   input  logic [uer_pkg::STATUS_BITS-1:0]        rsp_status,
   input  logic [uer_pkg::DIST_BITS-1:0]          rsp_distance_x16,
   input  logic signed [uer_pkg::LEVEL_BITS-1:0]  rsp_level_q14,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [uer_pkg::ADDR_BITS-1:0]          csr_paddr,
   input  logic [uer_pkg::DATA_BITS-1:0]          csr_pwdata,
   input  logic                                   csr_pready,
   output int                                     mismatch_count,
   output int                                     open_readings,
   output int                                     ranges_seen,
   output int                                     ping_timeouts_seen,
   output int                                     echo_timeouts_seen
);

   localparam bit [31:0] COUNT_MAX = 32'((64'd1 << COUNT_BITS) - 64'd1);
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic                                   trigger_drive;
      logic                                   drive_enable;
      logic                                   busy;
      logic                                   done;
      logic [uer_pkg::STATUS_BITS-1:0]        status;
      logic [uer_pkg::DIST_BITS-1:0]          distance;
      logic signed [uer_pkg::LEVEL_BITS-1:0]  level;
   } ranger_reading_type;

   ranger_reading_type pending_readings[$];

   logic [uer_pkg::TRIG_BITS-1:0]    trig_low   = uer_pkg::TRIG_LOW_RESET;
   logic [uer_pkg::TRIG_BITS-1:0]    trig_high  = uer_pkg::TRIG_HIGH_RESET;
   logic [uer_pkg::TIMEOUT_BITS-1:0] ping_limit = uer_pkg::PING_TO_RESET;
   logic [uer_pkg::TIMEOUT_BITS-1:0] echo_limit = uer_pkg::ECHO_TO_RESET;
   logic [uer_pkg::HEIGHT_BITS-1:0]  tank_h     = uer_pkg::TANK_H_RESET;

   uer_pkg::phase_type                     phase_now     = uer_pkg::PH_IDLE;
   bit [31:0]                              tick_now      = '0;
   logic [uer_pkg::DIST_BITS-1:0]          last_distance = '0;
   logic signed [uer_pkg::LEVEL_BITS-1:0]  last_level    = '0;
   logic [uer_pkg::STATUS_BITS-1:0]        last_status   = uer_pkg::ST_OK;

   int bad_total  = 0;
   int ok_total   = 0;
   int ping_total = 0;
   int echo_total = 0;

   assign mismatch_count     = bad_total;
   assign open_readings      = pending_readings.size();
   assign ranges_seen        = ok_total;
   assign ping_timeouts_seen = ping_total;
   assign echo_timeouts_seen = echo_total;

   function automatic bit [31:0] bump_count(bit [31:0] c);
      return (c < COUNT_MAX) ? c + 32'd1 : c;
   endfunction

   function automatic bit limit_hit(bit [31:0] c, bit [31:0] lim);
      return (c >= lim) || (c == COUNT_MAX);
   endfunction

   function void show_reading(string tag, ranger_reading_type r);
      $display("   %s drv=%0b en=%0b busy=%0b done=%0b st=%0d dist=%0d lvl=%0d", tag,
               r.trigger_drive, r.drive_enable, r.busy, r.done, r.status, r.distance,
               r.level);
   endfunction

   // distance is width/58 cm in sixteenths, level is (58H - width)/58H floored
   function void record_range(bit [31:0] width);
      longint height;
      longint den;
      longint num;
      longint q;
      height = (tank_h == 0) ? 64'sd1 : longint'(tank_h);
      den = height * uer_pkg::US_PER_CM;
      num = (den - longint'(width)) * uer_pkg::LEVEL_ONE;
      q = num / den;
      if ((num % den) != 0 && num < 0) q = q - 1;
      if (q < -32768) q = -32768;
      last_distance = uer_pkg::DIST_BITS'((longint'(width) * 16) / uer_pkg::US_PER_CM);
      last_level = q[uer_pkg::LEVEL_BITS-1:0];
      last_status = uer_pkg::ST_OK;
   endfunction

   function void store_setting(logic [uer_pkg::ADDR_BITS-1:0] addr,
                               logic [uer_pkg::DATA_BITS-1:0] data);
      case (uer_pkg::reg_index_type'(addr[uer_pkg::ADDR_BITS-1:2]))
         uer_pkg::REG_TRIG_LOW:  trig_low   = data[uer_pkg::TRIG_BITS-1:0];
         uer_pkg::REG_TRIG_HIGH: trig_high  = data[uer_pkg::TRIG_BITS-1:0];
         uer_pkg::REG_PING_TO:   ping_limit = data[uer_pkg::TIMEOUT_BITS-1:0];
         uer_pkg::REG_ECHO_TO:   echo_limit = data[uer_pkg::TIMEOUT_BITS-1:0];
         uer_pkg::REG_TANK_H:    tank_h     = data[uer_pkg::HEIGHT_BITS-1:0];
         default: ;
      endcase
   endfunction

   function void advance_ranger(input logic start, input logic echo,
                                output ranger_reading_type r);
      logic done;
      done = 1'b0;
      case (phase_now)
         uer_pkg::PH_IDLE: begin
            if (start) begin
               tick_now = '0;
               phase_now = (trig_low != 0) ? uer_pkg::PH_LOW : uer_pkg::PH_HIGH;
            end
         end
         uer_pkg::PH_LOW: begin
            tick_now = bump_count(tick_now);
            if (tick_now >= 32'(trig_low)) begin
               tick_now = '0;
               phase_now = uer_pkg::PH_HIGH;
            end
         end
         uer_pkg::PH_HIGH: begin
            tick_now = bump_count(tick_now);
            if (tick_now >= 32'(trig_high)) begin
               tick_now = '0;
               phase_now = uer_pkg::PH_WAIT;
            end
         end
         uer_pkg::PH_WAIT: begin
            if (echo) begin
               tick_now = 32'd1;
               phase_now = uer_pkg::PH_ECHO;
               if (limit_hit(tick_now, 32'(echo_limit))) begin
                  last_status = uer_pkg::ST_ECHO_TO;
                  phase_now = uer_pkg::PH_IDLE;
                  done = 1'b1;
               end
            end else begin
               tick_now = bump_count(tick_now);
               if (limit_hit(tick_now, 32'(ping_limit))) begin
                  last_status = uer_pkg::ST_PING_TO;
                  phase_now = uer_pkg::PH_IDLE;
                  done = 1'b1;
               end
            end
         end
         uer_pkg::PH_ECHO: begin
            if (echo) begin
               tick_now = bump_count(tick_now);
               if (limit_hit(tick_now, 32'(echo_limit))) begin
                  last_status = uer_pkg::ST_ECHO_TO;
                  phase_now = uer_pkg::PH_IDLE;
                  done = 1'b1;
               end
            end else begin
               record_range(tick_now);
               phase_now = uer_pkg::PH_IDLE;
               done = 1'b1;
            end
         end
         default: phase_now = uer_pkg::PH_IDLE;
      endcase
      r.trigger_drive = (phase_now == uer_pkg::PH_HIGH);
      r.drive_enable  = (phase_now == uer_pkg::PH_LOW) || (phase_now == uer_pkg::PH_HIGH);
      r.busy          = (phase_now != uer_pkg::PH_IDLE);
      r.done          = done;
      r.status        = last_status;
      r.distance      = last_distance;
      r.level         = last_level;
   endfunction

   always @(posedge clock) begin
      ranger_reading_type want;
      ranger_reading_type seen;
      if (reset) begin
         trig_low      = uer_pkg::TRIG_LOW_RESET;
         trig_high     = uer_pkg::TRIG_HIGH_RESET;
         ping_limit    = uer_pkg::PING_TO_RESET;
         echo_limit    = uer_pkg::ECHO_TO_RESET;
         tank_h        = uer_pkg::TANK_H_RESET;
         phase_now     = uer_pkg::PH_IDLE;
         tick_now      = '0;
         last_distance = '0;
         last_level    = '0;
         last_status   = uer_pkg::ST_OK;
         pending_readings.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            store_setting(csr_paddr, csr_pwdata);
         end
         if (rsp_valid && !rsp_stall) begin
            seen = '{rsp_trigger_drive, rsp_drive_enable, rsp_busy_res, rsp_done_res,
                     rsp_status, rsp_distance_x16, rsp_level_q14};
            if (pending_readings.size() == 0) begin
               bad_total++;
               if (bad_total <= REPORT_LIMIT) begin
                  $display("[%0t] result with nothing expected", $realtime);
                  show_reading("actual  ", seen);
               end
            end else begin
               want = pending_readings.pop_front();
               if (want.done) begin
                  case (want.status)
                     uer_pkg::ST_OK:      ok_total++;
                     uer_pkg::ST_PING_TO: ping_total++;
                     uer_pkg::ST_ECHO_TO: echo_total++;
                     default: ;
                  endcase
               end
               if (seen.trigger_drive !== want.trigger_drive ||
                   seen.drive_enable !== want.drive_enable ||
                   seen.busy !== want.busy || seen.done !== want.done ||
                   seen.status !== want.status || seen.distance !== want.distance ||
                   seen.level !== want.level) begin
                  bad_total++;
                  if (bad_total <= REPORT_LIMIT) begin
                     $display("[%0t] mismatch", $realtime);
                     show_reading("expected", want);
                     show_reading("actual  ", seen);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            advance_ranger(req_operation, req_echo_level, want);
            pending_readings.push_back(want);
         end
      end
   end

endmodule

### dv/tb_ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// tb_ultrasonic_echo_ranger
// Drives tick and start transactions into the echo ranger under a series of
// register settings, with random gaps on the request side and random stalls
// on the result side. A directed opening covers the reset settings, zero
// trigger times, zero timeouts and zero tank height; random phases then mix
// well-formed ranging sequences with noise. Checking lives in the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ultrasonic_echo_ranger;

   localparam int COUNT_BITS   = 22;
   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 10;
   localparam int MAX_GAP      = 12;
   localparam int RANDOM_ITEMS = 1050;
   localparam int PHASE_ITEMS  = 120;
   localparam int TAIL_CYCLES  = 100;
   localparam int QUIET_LIMIT  = 4000;
   localparam int TIMEOUT_MAX  = 4194303;

   logic                                   clock          = 1'b0;
   logic                                   reset          = 1'b1;
   logic                                   req_valid      = 1'b0;
   logic                                   req_stall;
   logic                                   req_operation  = 1'b0;
   logic                                   req_echo_level = 1'b0;
   logic                                   rsp_valid;
   logic                                   rsp_stall      = 1'b0;
   logic                                   rsp_trigger_drive;
   logic                                   rsp_drive_enable;
   logic                                   rsp_busy_res;
   logic                                   rsp_done_res;
   logic [uer_pkg::STATUS_BITS-1:0]        rsp_status;
   logic [uer_pkg::DIST_BITS-1:0]          rsp_distance_x16;
   logic signed [uer_pkg::LEVEL_BITS-1:0]  rsp_level_q14;
   logic                                   csr_psel       = 1'b0;
   logic                                   csr_penable    = 1'b0;
   logic                                   csr_pwrite     = 1'b0;
   logic [uer_pkg::ADDR_BITS-1:0]          csr_paddr      = '0;
   logic [uer_pkg::DATA_BITS-1:0]          csr_pwdata     = '0;
   logic [uer_pkg::DATA_BITS-1:0]          csr_prdata;
   logic                                   csr_pready;

   int mismatch_count;
   int open_readings;
   int ranges_seen;
   int ping_timeouts_seen;
   int echo_timeouts_seen;

   int cfg_low  = int'(uer_pkg::TRIG_LOW_RESET);
   int cfg_high = int'(uer_pkg::TRIG_HIGH_RESET);
   int cfg_ping = int'(uer_pkg::PING_TO_RESET);
   int cfg_echo = int'(uer_pkg::ECHO_TO_RESET);
   int cfg_h    = int'(uer_pkg::TANK_H_RESET);

   int   sent_items    = 0;
   int   setting_count = 1;
   int   hold_left     = 0;
   int   quiet_cycles  = 0;
   bit   calm          = 1'b0;
   logic rsp_took      = 1'b0;
   logic last_busy     = 1'b0;

   always #(HALF_PERIOD) clock = ~clock;

   ultrasonic_echo_ranger #(
      .COUNT_BITS(COUNT_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_echo_level(req_echo_level),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_trigger_drive(rsp_trigger_drive),
      .rsp_drive_enable(rsp_drive_enable),
      .rsp_busy_res(rsp_busy_res),
      .rsp_done_res(rsp_done_res),
      .rsp_status(rsp_status),
      .rsp_distance_x16(rsp_distance_x16),
      .rsp_level_q14(rsp_level_q14),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   ultrasonic_echo_ranger_checker #(
      .COUNT_BITS(COUNT_BITS)
   ) ranger_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_echo_level(req_echo_level),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_trigger_drive(rsp_trigger_drive),
      .rsp_drive_enable(rsp_drive_enable),
      .rsp_busy_res(rsp_busy_res),
      .rsp_done_res(rsp_done_res),
      .rsp_status(rsp_status),
      .rsp_distance_x16(rsp_distance_x16),
      .rsp_level_q14(rsp_level_q14),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_pready(csr_pready),
      .mismatch_count(mismatch_count),
      .open_readings(open_readings),
      .ranges_seen(ranges_seen),
      .ping_timeouts_seen(ping_timeouts_seen),
      .echo_timeouts_seen(echo_timeouts_seen)
   );

   // result side: fresh stall count per transaction, spent only while a result waits
   always @(posedge clock) begin
      rsp_took <= rsp_valid && !rsp_stall;
      if (rsp_valid && !rsp_stall) last_busy <= rsp_busy_res;
   end

   always @(negedge clock) begin
      if (rsp_took) hold_left = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         if (rsp_valid) hold_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[%0t] no transaction for %0d cycles", $realtime, QUIET_LIMIT);
         $display("** ultrasonic_echo_ranger: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input logic op, input logic echo);
      int gap;
      gap = calm ? 0 : $urandom_range(0, MAX_GAP);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_echo_level <= echo;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_items++;
      @(negedge clock);
   endtask

   task automatic wait_readings();
      while (open_readings != 0) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
   endtask

   // run out any measurement still in flight, echo toggling on each tick
   task automatic settle_ranger();
      logic echo;
      echo = 1'b0;
      wait_readings();
      while (last_busy) begin
         echo = !echo;
         send_item(1'b0, echo);
         wait_readings();
      end
   endtask

   task automatic csr_write(input uer_pkg::reg_index_type idx, input int value,
                            input int width);
      bit [31:0] mask;
      mask = (32'd1 << width) - 32'd1;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= ($urandom & ~mask) | (32'(value) & mask);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic apply_setting(input int lo, input int hi, input int pg, input int ec,
                                input int ht);
      settle_ranger();
      csr_write(uer_pkg::REG_TRIG_LOW, lo, uer_pkg::TRIG_BITS);
      csr_write(uer_pkg::REG_TRIG_HIGH, hi, uer_pkg::TRIG_BITS);
      csr_write(uer_pkg::REG_PING_TO, pg, uer_pkg::TIMEOUT_BITS);
      csr_write(uer_pkg::REG_ECHO_TO, ec, uer_pkg::TIMEOUT_BITS);
      csr_write(uer_pkg::REG_TANK_H, ht, uer_pkg::HEIGHT_BITS);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cfg_low  = lo;
      cfg_high = hi;
      cfg_ping = pg;
      cfg_echo = ec;
      cfg_h    = ht;
      setting_count++;
      @(negedge clock);
   endtask

   task automatic pick_setting(input int n, output int lo, output int hi, output int pg,
                               output int ec, output int ht);
      case (n)
         0: begin lo = 255; hi = 0;   pg = 30;          ec = 500;         ht = 1;     end
         1: begin lo = 0;   hi = 255; pg = 20;          ec = 300;         ht = 40;    end
         2: begin lo = 3;   hi = 2;   pg = TIMEOUT_MAX; ec = TIMEOUT_MAX; ht = 65535; end
         3: begin lo = 1;   hi = 1;   pg = 40;          ec = TIMEOUT_MAX; ht = 1;     end
         4: begin lo = 2;   hi = 1;   pg = 1;           ec = 1;           ht = 65535; end
         default: begin
            case ($urandom_range(0, 5))
               0: lo = 0;
               1: lo = 1;
               default: lo = $urandom_range(0, 8);
            endcase
            case ($urandom_range(0, 5))
               0: hi = 0;
               1: hi = 1;
               default: hi = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 5))
               0: pg = 0;
               1: pg = 1;
               2: pg = TIMEOUT_MAX;
               default: pg = $urandom_range(2, 40);
            endcase
            case ($urandom_range(0, 5))
               0: ec = 0;
               1: ec = 1;
               2: ec = TIMEOUT_MAX;
               3: ec = $urandom_range(2, 30);
               default: ec = $urandom_range(31, 500);
            endcase
            case ($urandom_range(0, 5))
               0: ht = 0;
               1: ht = 1;
               2: ht = 65535;
               3: ht = $urandom_range(2, 6);
               default: ht = $urandom_range(7, 3000);
            endcase
         end
      endcase
   endtask

   // start, trigger ticks, low-echo wait, echo pulse, falling edge
   task automatic run_measurement(input int min_echo);
      int trig_ticks;
      int ping_span;
      int wait_ticks;
      int echo_ticks;
      int pick;
      trig_ticks = cfg_low + ((cfg_high == 0) ? 1 : cfg_high);
      ping_span = (cfg_ping > 40) ? 40 : cfg_ping;
      wait_ticks = $urandom_range(0, ping_span);
      pick = $urandom_range(0, 99);
      if (pick < 70) echo_ticks = $urandom_range(1, 20);
      else if (pick < 95) echo_ticks = $urandom_range(21, 120);
      else echo_ticks = $urandom_range(121, 400);
      if (cfg_echo <= 400 && $urandom_range(0, 4) == 0) begin
         echo_ticks = cfg_echo + $urandom_range(0, 2);
      end
      if (echo_ticks < min_echo) echo_ticks = min_echo;
      send_item(1'b1, 1'($urandom_range(0, 1)));
      repeat (trig_ticks) send_item($urandom_range(0, 19) == 0, 1'($urandom_range(0, 1)));
      repeat (wait_ticks) send_item($urandom_range(0, 19) == 0, 1'b0);
      repeat (echo_ticks) send_item($urandom_range(0, 19) == 0, 1'b1);
      send_item(1'b0, 1'b0);
   endtask

   initial begin
      int directed_items;
      int setting_no;
      int phase_first;
      int lo;
      int hi;
      int pg;
      int ec;
      int ht;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: full sequence, start while busy inside the trigger pulse
      send_item(1'b1, 1'b1);
      repeat (6) send_item(1'b0, 1'b1);
      send_item(1'b1, 1'b0);
      repeat (7) send_item(1'b0, 1'b0);
      send_item(1'b0, 1'b0);
      send_item(1'b0, 1'b1);
      send_item(1'b0, 1'b1);
      send_item(1'b0, 1'b0);

      // zero low and high time, echo timeout on the rising sample
      apply_setting(0, 0, 1, 0, 0);
      send_item(1'b1, 1'b0);
      send_item(1'b0, 1'b0);
      send_item(1'b0, 1'b1);

      // ping timeout on the first counted sample
      apply_setting(0, 0, 0, 5, 0);
      send_item(1'b1, 1'b0);
      send_item(1'b0, 1'b0);
      send_item(1'b0, 1'b0);

      // good echo with zero tank height
      apply_setting(0, 0, 2, 3, 0);
      send_item(1'b1, 1'b0);
      send_item(1'b0, 1'b0);
      send_item(1'b0, 1'b1);
      send_item(1'b0, 1'b1);
      send_item(1'b0, 1'b0);
      directed_items = sent_items;

      setting_no = 0;
      while (sent_items - directed_items < RANDOM_ITEMS) begin
         pick_setting(setting_no, lo, hi, pg, ec, ht);
         apply_setting(lo, hi, pg, ec, ht);
         phase_first = sent_items;
         if (setting_no == 3) run_measurement(200);
         while (sent_items - phase_first < PHASE_ITEMS &&
                sent_items - directed_items < RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 4) == 0);
            if (cfg_ping <= 1000 && $urandom_range(0, 3) == 0) begin
               repeat ($urandom_range(1, 24)) begin
                  send_item($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
               end
            end else begin
               run_measurement(0);
            end
         end
         calm = 1'b0;
         setting_no++;
      end

      wait_readings();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("%0d transactions under %0d register settings", sent_items, setting_count);
      $display("measurements: %0d ranged, %0d ping timeouts, %0d echo timeouts",
               ranges_seen, ping_timeouts_seen, echo_timeouts_seen);
      if (mismatch_count == 0 && open_readings == 0) begin
         $display("** ultrasonic_echo_ranger: PASSED **");
      end else begin
         $display("** ultrasonic_echo_ranger: FAILED **");
      end
      $finish;
   end

endmodule
